/* sv/mfet_pkg.sv */
`timescale 1ns / 1ps

package mfet_pkg;

    // opcodes of an input word
    localparam logic OP_FRAME = 1'b0;
    localparam logic OP_READ  = 1'b1;

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESENT_MASK   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ONLINE_TIMEOUT = 1'b1;

    localparam logic [7:0]  PRESENT_MASK_RST   = 8'd0;
    localparam logic [31:0] ONLINE_TIMEOUT_RST = 32'd100;

    // frame filter and encoder geometry
    localparam logic [3:0]         DLC_FULL  = 4'd8;
    localparam logic signed [17:0] HALF_TURN = 18'sd4096;
    localparam logic signed [17:0] FULL_TURN = 18'sd8192;

    // registered input word
    typedef struct packed {
        logic        opcode;
        logic        is_extended;
        logic        is_remote;
        logic [3:0]  frame_length;
        logic [10:0] frame_id;
        logic [63:0] frame_data;
        logic [2:0]  read_slot;
        logic [31:0] cur_tick;
    } t_in_word;

    // result word
    typedef struct packed {
        logic               frame_accepted;
        logic [2:0]         slot;
        logic               fresh;
        logic [15:0]        angle;
        logic signed [15:0] rotor_speed;
        logic signed [15:0] motor_current;
        logic [7:0]         temperature;
        logic signed [31:0] multiturn_count;
        logic               online;
    } t_out_word;

    // controller to datapath commands
    typedef struct packed {
        logic load_in;
        logic exec;
    } t_cmd;

endpackage

/* sv/mfet_in_if.sv */
`timescale 1ns / 1ps

interface mfet_in_if;
    logic        valid;
    logic        ready;
    logic        opcode;
    logic        is_extended;
    logic        is_remote;
    logic [3:0]  frame_length;
    logic [10:0] frame_id;
    logic [63:0] frame_data;
    logic [2:0]  read_slot;
    logic [31:0] cur_tick;

    modport source (
        output valid, opcode, is_extended, is_remote, frame_length, frame_id,
               frame_data, read_slot, cur_tick,
        input  ready
    );

    modport sink (
        input  valid, opcode, is_extended, is_remote, frame_length, frame_id,
               frame_data, read_slot, cur_tick,
        output ready
    );
endinterface

/* sv/mfet_out_if.sv */
`timescale 1ns / 1ps

interface mfet_out_if;
    logic               valid;
    logic               ready;
    logic               frame_accepted;
    logic [2:0]         slot;
    logic               fresh;
    logic [15:0]        angle;
    logic signed [15:0] rotor_speed;
    logic signed [15:0] motor_current;
    logic [7:0]         temperature;
    logic signed [31:0] multiturn_count;
    logic               online;

    modport source (
        output valid, frame_accepted, slot, fresh, angle, rotor_speed, motor_current,
               temperature, multiturn_count, online,
        input  ready
    );

    modport sink (
        input  valid, frame_accepted, slot, fresh, angle, rotor_speed, motor_current,
               temperature, multiturn_count, online,
        output ready
    );
endinterface

/* sv/mfet_ctrl.sv */
`timescale 1ns / 1ps

module mfet_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output mfet_pkg::t_cmd o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_accept;
    logic   w_exec;

    assign o_in_ready  = (r_state == S_IDLE);
    assign w_accept    = i_in_valid && o_in_ready;
    // execute only when the output register is free or being emptied
    assign w_exec      = (r_state == S_EXEC) && (!r_out_valid || i_out_ready);
    assign o_out_valid = r_out_valid;

    assign o_cmd.load_in = w_accept;
    assign o_cmd.exec    = w_exec;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) n_state = S_EXEC;
            end
            S_EXEC: begin
                if (w_exec) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // output word valid
    always_comb begin
        n_out_valid = r_out_valid;
        if (w_exec) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // an accepted word always moves to the execute state
    a_accept_to_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_EXEC))
        else $error("accepted word did not move to execute");

    // never overwrite a result that is still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_exec |-> (!r_out_valid || i_out_ready))
        else $error("result overwritten before it was taken");

    // every execution presents a result word
    a_exec_gives_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_exec |=> r_out_valid)
        else $error("execution produced no result word");

endmodule

/* sv/mfet_dp.sv */
`timescale 1ns / 1ps

module mfet_dp #(
    parameter int SLOTS   = 8,
    parameter int BASE_ID = 513
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  mfet_pkg::t_cmd                     i_cmd,
    input  mfet_pkg::t_in_word                 i_in_word,
    input  logic                               i_cfg_we,
    input  logic [mfet_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [mfet_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output mfet_pkg::t_out_word                o_out_word
);

    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [11:0] ID_LO = 12'(BASE_ID);
    localparam logic [11:0] ID_HI = 12'(BASE_ID + SLOTS);
    localparam logic [3:0]  SLOT_LIM = 4'(SLOTS);

    // configuration
    logic [7:0]  r_present_mask;
    logic [31:0] r_online_timeout;

    // input and output registers
    mfet_pkg::t_in_word  r_in;
    mfet_pkg::t_out_word r_out, n_out;

    // per-slot state
    logic [15:0] r_ref_angle [SLOTS];
    logic [31:0] r_turn_total [SLOTS];
    logic [15:0] r_angle [SLOTS];
    logic [15:0] r_speed [SLOTS];
    logic [15:0] r_current [SLOTS];
    logic [7:0]  r_temp [SLOTS];
    logic [31:0] r_arrival [SLOTS];
    logic [SLOTS-1:0] r_started, r_seen, r_fresh;

    logic [10:0]        w_id_off;
    logic [2:0]         w_frame_slot;
    logic               w_id_ok;
    logic               w_frame_ok;
    logic [2:0]         w_slot;
    logic               w_slot_ok;
    logic [SW-1:0]      w_idx;
    logic [15:0]        w_ang;
    logic signed [17:0] w_diff;
    logic signed [17:0] w_step;
    logic [31:0]        w_total_new;
    logic [31:0]        w_gap;
    logic               w_online;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_present_mask   <= mfet_pkg::PRESENT_MASK_RST;
            r_online_timeout <= mfet_pkg::ONLINE_TIMEOUT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                mfet_pkg::CFG_PRESENT_MASK:   r_present_mask   <= i_cfg_data[7:0];
                mfet_pkg::CFG_ONLINE_TIMEOUT: r_online_timeout <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // input capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) r_in <= i_in_word;
    end

    // frame filter
    assign w_id_ok      = ({1'b0, r_in.frame_id} >= ID_LO) && ({1'b0, r_in.frame_id} < ID_HI);
    assign w_id_off     = r_in.frame_id - ID_LO[10:0];
    assign w_frame_slot = w_id_off[2:0];
    assign w_frame_ok   = (r_in.opcode == mfet_pkg::OP_FRAME) && !r_in.is_extended
                          && !r_in.is_remote && (r_in.frame_length == mfet_pkg::DLC_FULL)
                          && w_id_ok && r_present_mask[w_frame_slot];

    // slot addressed by this word
    assign w_slot    = (r_in.opcode == mfet_pkg::OP_READ) ? r_in.read_slot : w_frame_slot;
    assign w_slot_ok = ({1'b0, w_slot} < SLOT_LIM);
    assign w_idx     = w_slot[SW-1:0];

    // angle unwrap: fold the step into half a turn either way
    assign w_ang  = r_in.frame_data[63:48];
    assign w_diff = $signed({2'b00, w_ang}) - $signed({2'b00, r_ref_angle[w_idx]});
    always_comb begin
        if (w_diff > mfet_pkg::HALF_TURN) begin
            w_step = w_diff - mfet_pkg::FULL_TURN;
        end else if (w_diff < -mfet_pkg::HALF_TURN) begin
            w_step = w_diff + mfet_pkg::FULL_TURN;
        end else begin
            w_step = w_diff;
        end
    end
    assign w_total_new = r_started[w_idx]
                         ? r_turn_total[w_idx] + {{14{w_step[17]}}, w_step}
                         : 32'd0;

    // online check, tick gap wraps mod 2^32
    assign w_gap    = r_in.cur_tick - r_arrival[w_idx];
    assign w_online = r_seen[w_idx] && (w_gap <= r_online_timeout);

    // result word
    always_comb begin
        n_out = '0;
        if (r_in.opcode == mfet_pkg::OP_FRAME) begin
            if (w_frame_ok) begin
                n_out.frame_accepted = 1'b1;
                n_out.slot           = w_frame_slot;
            end
        end else begin
            n_out.slot = r_in.read_slot;
            if (w_slot_ok) begin
                n_out.online = w_online;
                if (r_fresh[w_idx]) begin
                    n_out.fresh           = 1'b1;
                    n_out.angle           = r_angle[w_idx];
                    n_out.rotor_speed     = r_speed[w_idx];
                    n_out.motor_current   = r_current[w_idx];
                    n_out.temperature     = r_temp[w_idx];
                    n_out.multiturn_count = r_turn_total[w_idx];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) r_out <= n_out;
    end
    assign o_out_word = r_out;

    // slot payload update
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && w_frame_ok) begin
            r_ref_angle[w_idx]  <= w_ang;
            r_turn_total[w_idx] <= w_total_new;
            r_angle[w_idx]      <= w_ang;
            r_speed[w_idx]      <= r_in.frame_data[47:32];
            r_current[w_idx]    <= r_in.frame_data[31:16];
            r_temp[w_idx]       <= r_in.frame_data[15:8];
            r_arrival[w_idx]    <= r_in.cur_tick;
        end
    end

    // slot status bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_started <= '0;
            r_seen    <= '0;
            r_fresh   <= '0;
        end else if (i_cmd.exec) begin
            if (w_frame_ok) begin
                r_started[w_idx] <= 1'b1;
                r_seen[w_idx]    <= 1'b1;
                r_fresh[w_idx]   <= 1'b1;
            end else if ((r_in.opcode == mfet_pkg::OP_READ) && w_slot_ok) begin
                r_fresh[w_idx]   <= 1'b0;
            end
        end
    end

endmodule

/* sv/motor_feedback_encoder_tracker_unit.sv */
`timescale 1ns / 1ps

// Feedback tracker for up to SLOTS motors on a CAN bus. Opcode 0 words carry
// a received frame: a standard data frame of DLC 8 whose ID lies in BASE_ID to
// BASE_ID+SLOTS-1 and whose slot is set in present_mask updates that slot
// (angle, speed, current, temperature, tick stamp, fresh flag) and unwraps the
// angle into a 32-bit multi-turn total. Opcode 1 words read a slot, return its
// feedback once if fresh, and always return its online status. Each word is
// first registered, then used for the slot read-modify-write in the datapath;
// a new word is taken only once the last one has executed. The next word is
// accepted while a result still waits in the output register; execution holds
// only while that register is full and not being taken. Configuration writes
// (index 0 present_mask, index 1 online_timeout) are taken in any cycle.
module motor_feedback_encoder_tracker_unit #(
    parameter int SLOTS   = 8,
    parameter int BASE_ID = 513
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    mfet_in_if.sink                         i_in,
    mfet_out_if.source                      o_out,
    input  logic                            i_cfg_we,
    input  logic [mfet_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [mfet_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    mfet_pkg::t_cmd      w_cmd;
    mfet_pkg::t_in_word  w_in_word;
    mfet_pkg::t_out_word w_out_word;

    // pack the incoming word
    assign w_in_word.opcode       = i_in.opcode;
    assign w_in_word.is_extended  = i_in.is_extended;
    assign w_in_word.is_remote    = i_in.is_remote;
    assign w_in_word.frame_length = i_in.frame_length;
    assign w_in_word.frame_id     = i_in.frame_id;
    assign w_in_word.frame_data   = i_in.frame_data;
    assign w_in_word.read_slot    = i_in.read_slot;
    assign w_in_word.cur_tick     = i_in.cur_tick;

    mfet_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_cmd       (w_cmd)
    );

    mfet_dp #(
        .SLOTS   (SLOTS),
        .BASE_ID (BASE_ID)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .i_in_word  (w_in_word),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_out_word (w_out_word)
    );

    // unpack the result word
    assign o_out.frame_accepted  = w_out_word.frame_accepted;
    assign o_out.slot            = w_out_word.slot;
    assign o_out.fresh           = w_out_word.fresh;
    assign o_out.angle           = w_out_word.angle;
    assign o_out.rotor_speed     = w_out_word.rotor_speed;
    assign o_out.motor_current   = w_out_word.motor_current;
    assign o_out.temperature     = w_out_word.temperature;
    assign o_out.multiturn_count = w_out_word.multiturn_count;
    assign o_out.online          = w_out_word.online;

endmodule

/* dv/tb_motor_feedback_encoder_tracker_unit.sv */
`timescale 1ns / 1ps

module tb_motor_feedback_encoder_tracker_unit;

    localparam int NUM_SLOTS    = 8;
    localparam int FIRST_ID     = 513;
    localparam int RANDOM_WORDS = 1500;
    localparam int PHASES       = 12;
    localparam int MAX_GAP      = 16;
    localparam int LONG_HOLD    = 400;
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 500000;

    typedef enum logic {ROW_WORD, ROW_CFG} t_row_kind;

    // one line of the directed stimulus table
    typedef struct {
        t_row_kind                       kind;
        mfet_pkg::t_in_word              word;
        logic                            typed;
        mfet_pkg::t_out_word             result;
        logic [mfet_pkg::CFG_IDX_W-1:0]  cfg_idx;
        logic [mfet_pkg::CFG_DATA_W-1:0] cfg_data;
    } t_stim_row;

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            cfg_we;
    logic [mfet_pkg::CFG_IDX_W-1:0]  cfg_idx;
    logic [mfet_pkg::CFG_DATA_W-1:0] cfg_data;

    mfet_in_if  in_if ();
    mfet_out_if out_if ();

    motor_feedback_encoder_tracker_unit #(
        .SLOTS   (NUM_SLOTS),
        .BASE_ID (FIRST_ID)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_if),
        .o_out      (out_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    // tracker state as the testbench sees it
    logic [7:0]  present_mask_q;
    logic [31:0] online_timeout_q;
    logic [15:0] ref_angle   [NUM_SLOTS];
    logic        unwrap_on   [NUM_SLOTS];
    logic [31:0] turn_count  [NUM_SLOTS];
    logic [15:0] fb_angle    [NUM_SLOTS];
    logic [15:0] fb_speed    [NUM_SLOTS];
    logic [15:0] fb_current  [NUM_SLOTS];
    logic [7:0]  fb_temp     [NUM_SLOTS];
    logic [31:0] stamp_tick  [NUM_SLOTS];
    logic        slot_seen   [NUM_SLOTS];
    logic        slot_fresh  [NUM_SLOTS];

    mfet_pkg::t_out_word feedback_due [$];
    mfet_pkg::t_out_word due_word;
    int                  fail_count = 0;

    // pacing knobs shared by the driving processes
    logic source_no_gaps = 1'b0;
    logic sink_no_gaps   = 1'b0;
    logic hold_off_req   = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // result word of one input word; updates the tracker state
    function automatic mfet_pkg::t_out_word predict_feedback(mfet_pkg::t_in_word w);
        mfet_pkg::t_out_word r;
        int                  s;
        int                  d;
        logic [15:0]         ang;
        logic [31:0]         age;
        r = '0;
        if (w.opcode == mfet_pkg::OP_FRAME) begin
            if (w.is_extended || w.is_remote || w.frame_length != mfet_pkg::DLC_FULL)
                return r;
            if (int'(w.frame_id) < FIRST_ID || int'(w.frame_id) >= FIRST_ID + NUM_SLOTS)
                return r;
            s = int'(w.frame_id) - FIRST_ID;
            if (!present_mask_q[s])
                return r;
            ang = w.frame_data[63:48];
            if (!unwrap_on[s]) begin
                turn_count[s] = '0;
                unwrap_on[s]  = 1'b1;
            end else begin
                // fold the step into one half turn either way
                d = int'(ang) - int'(ref_angle[s]);
                if (d > mfet_pkg::HALF_TURN)
                    d -= mfet_pkg::FULL_TURN;
                else if (d < -mfet_pkg::HALF_TURN)
                    d += mfet_pkg::FULL_TURN;
                turn_count[s] = turn_count[s] + 32'(d);
            end
            ref_angle[s]  = ang;
            fb_angle[s]   = ang;
            fb_speed[s]   = w.frame_data[47:32];
            fb_current[s] = w.frame_data[31:16];
            fb_temp[s]    = w.frame_data[15:8];
            stamp_tick[s] = w.cur_tick;
            slot_seen[s]  = 1'b1;
            slot_fresh[s] = 1'b1;
            r.frame_accepted = 1'b1;
            r.slot           = 3'(s);
        end else begin
            s      = int'(w.read_slot);
            r.slot = w.read_slot;
            if (s >= NUM_SLOTS)
                return r;
            if (slot_fresh[s]) begin
                r.fresh           = 1'b1;
                r.angle           = fb_angle[s];
                r.rotor_speed     = fb_speed[s];
                r.motor_current   = fb_current[s];
                r.temperature     = fb_temp[s];
                r.multiturn_count = turn_count[s];
                slot_fresh[s]     = 1'b0;
            end
            age      = w.cur_tick - stamp_tick[s];
            r.online = slot_seen[s] && (age <= online_timeout_q);
        end
        return r;
    endfunction

    function automatic t_stim_row frame_row(logic [10:0] id, logic [63:0] data,
                                            logic [31:0] tick, logic ext = 1'b0,
                                            logic rem = 1'b0,
                                            logic [3:0] dlc = mfet_pkg::DLC_FULL);
        t_stim_row r;
        r.kind              = ROW_WORD;
        r.word              = '0;
        r.word.opcode       = mfet_pkg::OP_FRAME;
        r.word.is_extended  = ext;
        r.word.is_remote    = rem;
        r.word.frame_length = dlc;
        r.word.frame_id     = id;
        r.word.frame_data   = data;
        r.word.read_slot    = 3'($urandom);
        r.word.cur_tick     = tick;
        r.typed             = 1'b0;
        r.result            = '0;
        r.cfg_idx           = '0;
        r.cfg_data          = '0;
        return r;
    endfunction

    function automatic t_stim_row read_row(logic [2:0] slot, logic [31:0] tick);
        t_stim_row r;
        r = frame_row(11'($urandom), {$urandom, $urandom}, tick, 1'($urandom),
                      1'($urandom), 4'($urandom));
        r.word.opcode    = mfet_pkg::OP_READ;
        r.word.read_slot = slot;
        return r;
    endfunction

    function automatic t_stim_row cfg_row(logic [mfet_pkg::CFG_IDX_W-1:0] idx,
                                          logic [mfet_pkg::CFG_DATA_W-1:0] data);
        t_stim_row r;
        r          = frame_row('0, '0, '0);
        r.kind     = ROW_CFG;
        r.cfg_idx  = idx;
        r.cfg_data = data;
        return r;
    endfunction

    function automatic t_stim_row with_result(t_stim_row r, mfet_pkg::t_out_word o);
        r.typed  = 1'b1;
        r.result = o;
        return r;
    endfunction

    function automatic mfet_pkg::t_out_word plain_result(logic acc, logic [2:0] slot);
        mfet_pkg::t_out_word o;
        o                = '0;
        o.frame_accepted = acc;
        o.slot           = slot;
        return o;
    endfunction

    function automatic logic [63:0] payload(logic [15:0] ang, logic [15:0] spd,
                                            logic [15:0] cur, logic [7:0] tmp);
        return {ang, spd, cur, tmp, 8'hC3};
    endfunction

    // offer one word, then queue its expected result once it is taken
    task automatic send_word(mfet_pkg::t_in_word w, logic typed,
                             mfet_pkg::t_out_word typed_result);
        int                  gap;
        mfet_pkg::t_out_word predicted;
        gap = source_no_gaps ? 0 : $urandom_range(0, MAX_GAP);
        repeat (gap) @(negedge i_clk) in_if.valid <= 1'b0;
        @(negedge i_clk);
        in_if.valid        <= 1'b1;
        in_if.opcode       <= w.opcode;
        in_if.is_extended  <= w.is_extended;
        in_if.is_remote    <= w.is_remote;
        in_if.frame_length <= w.frame_length;
        in_if.frame_id     <= w.frame_id;
        in_if.frame_data   <= w.frame_data;
        in_if.read_slot    <= w.read_slot;
        in_if.cur_tick     <= w.cur_tick;
        do @(posedge i_clk); while (!(in_if.valid && in_if.ready));
        predicted = predict_feedback(w);
        feedback_due.push_back(typed ? typed_result : predicted);
    endtask

    // stop offering and let every outstanding result drain
    task automatic wait_idle();
        @(negedge i_clk) in_if.valid <= 1'b0;
        while (feedback_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_cfg(logic [mfet_pkg::CFG_IDX_W-1:0] idx,
                             logic [mfet_pkg::CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(negedge i_clk);
        cfg_we <= 1'b0;
        if (idx == mfet_pkg::CFG_PRESENT_MASK)
            present_mask_q = data[7:0];
        else
            online_timeout_q = data;
    endtask

    task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %h, got %h", name, want, got);
            fail_count++;
        end
    endtask

    // result side: random stalls, one long hold-off on request
    initial begin : result_sink
        int stall;
        out_if.ready = 1'b0;
        forever begin
            stall = sink_no_gaps ? 0 : $urandom_range(0, MAX_GAP);
            if (hold_off_req) begin
                stall        = LONG_HOLD;
                hold_off_req = 1'b0;
            end
            repeat (stall) @(negedge i_clk) out_if.ready <= 1'b0;
            @(negedge i_clk) out_if.ready <= 1'b1;
            do @(posedge i_clk); while (!(out_if.valid && out_if.ready));
        end
    end

    // compare every taken result word with the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (feedback_due.size() == 0) begin
                $error("result word with nothing expected");
                fail_count++;
            end else begin
                due_word = feedback_due.pop_front();
                compare_field("frame_accepted", 32'(due_word.frame_accepted),
                              32'(out_if.frame_accepted));
                compare_field("slot", 32'(due_word.slot), 32'(out_if.slot));
                compare_field("fresh", 32'(due_word.fresh), 32'(out_if.fresh));
                compare_field("angle", 32'(due_word.angle), 32'(out_if.angle));
                compare_field("rotor_speed", 32'(due_word.rotor_speed),
                              32'(out_if.rotor_speed));
                compare_field("motor_current", 32'(due_word.motor_current),
                              32'(out_if.motor_current));
                compare_field("temperature", 32'(due_word.temperature),
                              32'(out_if.temperature));
                compare_field("multiturn_count", due_word.multiturn_count,
                              out_if.multiturn_count);
                compare_field("online", 32'(due_word.online), 32'(out_if.online));
            end
        end
    end

    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("Regression FAIL");
        $finish;
    end

    initial begin : stimulus
        t_stim_row           rows [$];
        t_stim_row           row;
        mfet_pkg::t_out_word full_read;
        mfet_pkg::t_in_word  w;
        logic [15:0]         ang;
        logic [15:0]         walk_angle [NUM_SLOTS];
        logic [31:0]         tick_now;
        int                  s;

        i_rst_n            = 1'b0;
        cfg_we             = 1'b0;
        cfg_idx            = '0;
        cfg_data           = '0;
        in_if.valid        = 1'b0;
        in_if.opcode       = mfet_pkg::OP_FRAME;
        in_if.is_extended  = 1'b0;
        in_if.is_remote    = 1'b0;
        in_if.frame_length = '0;
        in_if.frame_id     = '0;
        in_if.frame_data   = '0;
        in_if.read_slot    = '0;
        in_if.cur_tick     = '0;

        present_mask_q   = mfet_pkg::PRESENT_MASK_RST;
        online_timeout_q = mfet_pkg::ONLINE_TIMEOUT_RST;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            ref_angle[i]  = '0;
            unwrap_on[i]  = 1'b0;
            turn_count[i] = '0;
            fb_angle[i]   = '0;
            fb_speed[i]   = '0;
            fb_current[i] = '0;
            fb_temp[i]    = '0;
            stamp_tick[i] = '0;
            slot_seen[i]  = 1'b0;
            slot_fresh[i] = 1'b0;
            walk_angle[i] = '0;
        end

        repeat (10) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        full_read               = plain_result(1'b0, 3'd7);
        full_read.fresh         = 1'b1;
        full_read.angle         = 16'hFFFF;
        full_read.rotor_speed   = 16'hFFFF;
        full_read.motor_current = 16'hFFFF;
        full_read.temperature   = 8'hFF;
        full_read.online        = 1'b1;

        // directed: empty slots, filters, extremes, unwrap boundaries, timeout edges
        rows.push_back(with_result(read_row(3'd0, 32'd0), plain_result(1'b0, 3'd0)));
        rows.push_back(with_result(read_row(3'd7, 32'hFFFF_FFFF), plain_result(1'b0, 3'd7)));
        rows.push_back(with_result(frame_row(11'd513, '1, 32'd5), plain_result(1'b0, 3'd0)));
        rows.push_back(cfg_row(mfet_pkg::CFG_PRESENT_MASK, 32'hFF));
        rows.push_back(with_result(frame_row(11'd513, '1, 32'd5, 1'b1),
                                   plain_result(1'b0, 3'd0)));
        rows.push_back(with_result(frame_row(11'd513, '1, 32'd5, 1'b0, 1'b1),
                                   plain_result(1'b0, 3'd0)));
        rows.push_back(with_result(frame_row(11'd513, '1, 32'd5, 1'b0, 1'b0, 4'd7),
                                   plain_result(1'b0, 3'd0)));
        rows.push_back(with_result(frame_row(11'd513, '1, 32'd5, 1'b0, 1'b0, 4'd15),
                                   plain_result(1'b0, 3'd0)));
        rows.push_back(with_result(frame_row(11'd512, '1, 32'd5), plain_result(1'b0, 3'd0)));
        rows.push_back(with_result(frame_row(11'd521, '1, 32'd5), plain_result(1'b0, 3'd0)));
        rows.push_back(with_result(frame_row(11'd2047, '1, 32'd5), plain_result(1'b0, 3'd0)));
        rows.push_back(with_result(frame_row(11'd513, '0, 32'd0), plain_result(1'b1, 3'd0)));
        rows.push_back(with_result(frame_row(11'd520, '1, 32'hFFFF_FFFF),
                                   plain_result(1'b1, 3'd7)));
        rows.push_back(with_result(read_row(3'd7, 32'hFFFF_FFFF), full_read));
        rows.push_back(read_row(3'd7, 32'd99));
        rows.push_back(read_row(3'd7, 32'd100));
        rows.push_back(frame_row(11'd513, payload(16'd8191, 16'h8000, 16'h7FFF, 8'h00), 0));
        rows.push_back(frame_row(11'd513, payload(16'd0, 16'h7FFF, 16'h8000, 8'h80), 0));
        rows.push_back(frame_row(11'd513, payload(16'd4096, 16'h0001, 16'hFFFF, 8'h01), 0));
        rows.push_back(frame_row(11'd513, payload(16'd0, 16'hFFFF, 16'h0001, 8'hFE), 0));
        rows.push_back(frame_row(11'd513, payload(16'd4097, 16'h1234, 16'hABCD, 8'h5A), 0));
        rows.push_back(frame_row(11'd513, payload(16'hFFFF, 16'h4321, 16'h5555, 8'hA5), 0));
        rows.push_back(read_row(3'd0, 32'd100));
        rows.push_back(read_row(3'd0, 32'd101));
        rows.push_back(cfg_row(mfet_pkg::CFG_PRESENT_MASK, 32'h00));
        rows.push_back(with_result(frame_row(11'd513, '1, 32'd0), plain_result(1'b0, 3'd0)));
        rows.push_back(cfg_row(mfet_pkg::CFG_ONLINE_TIMEOUT, 32'd0));
        rows.push_back(read_row(3'd0, 32'd0));
        rows.push_back(read_row(3'd0, 32'd1));
        rows.push_back(cfg_row(mfet_pkg::CFG_ONLINE_TIMEOUT, 32'hFFFF_FFFF));
        rows.push_back(read_row(3'd3, 32'd5));
        rows.push_back(read_row(3'd7, 32'd12345));

        foreach (rows[i]) begin
            row = rows[i];
            if (row.kind == ROW_CFG) begin
                wait_idle();
                write_cfg(row.cfg_idx, row.cfg_data);
            end else begin
                send_word(row.word, row.typed, row.result);
            end
        end

        // random phases, each under its own register setting
        tick_now = 32'd0;
        for (int p = 0; p < PHASES; p++) begin
            wait_idle();
            case (p)
                0: begin
                    write_cfg(mfet_pkg::CFG_PRESENT_MASK, 32'hFF);
                    write_cfg(mfet_pkg::CFG_ONLINE_TIMEOUT, 32'd100);
                end
                1: begin
                    write_cfg(mfet_pkg::CFG_PRESENT_MASK, 32'($urandom_range(0, 255)));
                    write_cfg(mfet_pkg::CFG_ONLINE_TIMEOUT, 32'd0);
                end
                2: begin
                    write_cfg(mfet_pkg::CFG_PRESENT_MASK, 32'hFF);
                    write_cfg(mfet_pkg::CFG_ONLINE_TIMEOUT, 32'hFFFF_FFFF);
                end
                3: begin
                    write_cfg(mfet_pkg::CFG_PRESENT_MASK, 32'h00);
                    write_cfg(mfet_pkg::CFG_ONLINE_TIMEOUT, 32'($urandom_range(0, 200)));
                end
                default: begin
                    write_cfg(mfet_pkg::CFG_PRESENT_MASK,
                              32'($urandom_range(0, 255) | 8'h81));
                    write_cfg(mfet_pkg::CFG_ONLINE_TIMEOUT, ($urandom_range(0, 5) == 0) ?
                              32'($urandom) : 32'($urandom_range(0, 120)));
                end
            endcase
            source_no_gaps = (p == 2) || ($urandom_range(0, 4) == 0);
            sink_no_gaps   = ($urandom_range(0, 4) == 0);
            // long output hold-off while words keep coming in
            if (p == 2)
                hold_off_req = 1'b1;

            for (int n = 0; n < RANDOM_WORDS / PHASES; n++) begin
                if (p == 6 && n == 60)
                    wait_idle();
                case ($urandom_range(0, 19))
                    0:       tick_now = $urandom;
                    1:       tick_now = 32'hFFFF_FFFF - 32'($urandom_range(0, 50));
                    default: tick_now = tick_now + 32'($urandom_range(0, 40));
                endcase
                w.opcode       = ($urandom_range(0, 99) < 40) ? mfet_pkg::OP_READ
                                                              : mfet_pkg::OP_FRAME;
                w.is_extended  = 1'($urandom);
                w.is_remote    = 1'($urandom);
                w.frame_length = 4'($urandom);
                w.frame_id     = 11'($urandom);
                w.frame_data   = {$urandom, $urandom};
                w.read_slot    = 3'($urandom);
                w.cur_tick     = tick_now;
                // mostly well-formed feedback frames with a plausible angle walk
                if (w.opcode == mfet_pkg::OP_FRAME && $urandom_range(0, 99) < 75) begin
                    s              = $urandom_range(0, NUM_SLOTS - 1);
                    w.is_extended  = 1'b0;
                    w.is_remote    = 1'b0;
                    w.frame_length = mfet_pkg::DLC_FULL;
                    w.frame_id     = 11'(FIRST_ID + s);
                    case ($urandom_range(0, 3))
                        0: ang = 16'($urandom);
                        1: ang = $urandom_range(0, 1) ?
                                 walk_angle[s] + 16'(4094 + $urandom_range(0, 4)) :
                                 walk_angle[s] - 16'(4094 + $urandom_range(0, 4));
                        default: ang = (walk_angle[s] + 16'($urandom_range(0, 2000))
                                        - 16'd1000) & 16'h1FFF;
                    endcase
                    w.frame_data[63:48] = ang;
                    walk_angle[s]       = ang;
                end
                send_word(w, 1'b0, '0);
            end
        end

        wait_idle();
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
